// File: hw/rtl/zbuffer_pixel_plotter_macros.svh
// Assertion macros shared by the RTL files of the pixel plotter.
// No dependencies; included by the files that carry assertions.
`ifndef ZBUFFER_PIXEL_PLOTTER_MACROS_SVH
`define ZBUFFER_PIXEL_PLOTTER_MACROS_SVH

// Checked on every rising clk edge outside reset.
`define ZBP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked on every rising clk edge, reset included.
`define ZBP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: hw/rtl/zbp_pkg.sv
// Types and constants of the depth-tested pixel plotter.
// No dependencies; used by zbuffer_pixel_plotter.
package zbp_pkg;

  localparam int unsigned DEF_SCREEN_WIDTH  = 512;
  localparam int unsigned DEF_SCREEN_HEIGHT = 512;

  localparam int unsigned POS_W    = 16;
  localparam int unsigned DEPTH_W  = 32;
  localparam int unsigned ZSTORE_W = 31;   // stored depth, sign bit dropped
  localparam int unsigned COORD_W  = 9;
  localparam int unsigned COLOR_W  = 8;

  typedef struct packed {
    logic signed [POS_W-1:0]   pos_x;
    logic signed [POS_W-1:0]   pos_y;
    logic signed [DEPTH_W-1:0] depth;
    logic [COLOR_W-1:0]        red;
    logic [COLOR_W-1:0]        green;
    logic [COLOR_W-1:0]        blue;
  } point_t;

  typedef struct packed {
    logic                 write_enable;
    logic [COORD_W-1:0]   screen_x;
    logic [COORD_W-1:0]   screen_y;
    logic [COLOR_W-1:0]   out_red;
    logic [COLOR_W-1:0]   out_green;
    logic [COLOR_W-1:0]   out_blue;
  } pixel_t;

endpackage

// File: hw/rtl/zbuffer_pixel_plotter.sv
// Depth-tested pixel plotter top level: clip, depth test, framebuffer write.
// Depends on zbp_pkg, zbp_ram and zbuffer_pixel_plotter_macros.svh.
//
// One pixel request comes out for every point request: a taken point is registered in stage 1
// and then in the pix output register, and a new point is taken every cycle while the output
// side is not stalled. A point that is off screen, has negative depth, or loses the depth
// test (stored depth nonzero and smaller) yields a request with write_enable low and all
// other fields zero. The depth store is one SCREEN_WIDTH*SCREEN_HEIGHT x 31 RAM, read at the
// edge that takes the point and written back at the edge that moves the point to the output;
// the last write is forwarded so back-to-back points on one pixel see each other. After
// reset the store is swept to zero one entry per cycle through the RAM's single write port,
// with pt_stall held high until all SCREEN_WIDTH*SCREEN_HEIGHT entries are cleared.
`include "zbuffer_pixel_plotter_macros.svh"

module zbuffer_pixel_plotter #(
  parameter int unsigned SCREEN_WIDTH  = zbp_pkg::DEF_SCREEN_WIDTH,
  parameter int unsigned SCREEN_HEIGHT = zbp_pkg::DEF_SCREEN_HEIGHT
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            pt_valid,
  output logic            pt_stall,
  input  zbp_pkg::point_t pt,
  output logic            pix_valid,
  input  logic            pix_stall,
  output zbp_pkg::pixel_t pix
);

  localparam int unsigned ENTRIES = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int unsigned AW      = $clog2(ENTRIES);
  localparam int unsigned PW      = zbp_pkg::POS_W;
  localparam int unsigned RW      = PW + 1;   // recentred coordinate
  localparam int unsigned ZW      = zbp_pkg::ZSTORE_W;
  localparam int unsigned CW      = zbp_pkg::COORD_W;
  localparam int unsigned KW      = zbp_pkg::COLOR_W;
  localparam logic signed [RW-1:0]           HALF_W  = RW'(SCREEN_WIDTH / 2);
  localparam logic signed [RW-1:0]           HALF_H  = RW'(SCREEN_HEIGHT / 2);
  localparam logic [PW-1:0]                  LIMIT_X = PW'(SCREEN_WIDTH);
  localparam logic [PW-1:0]                  LIMIT_Y = PW'(SCREEN_HEIGHT);
  localparam logic [AW-1:0]                  ROW_STEP = AW'(SCREEN_WIDTH);
  localparam logic [AW-1:0]                  LAST_ENTRY = AW'(ENTRIES - 1);

  // clear sweep
  logic          clearing;
  logic [AW-1:0] clr_addr;

  // stage 1: waiting on RAM read data
  logic          s1_valid;
  logic          s1_ok;        // on screen and nonnegative depth
  logic [AW-1:0] s1_addr;
  logic [ZW-1:0] s1_depth;
  logic [CW-1:0] s1_x;
  logic [CW-1:0] s1_y;
  logic [KW-1:0] s1_red;
  logic [KW-1:0] s1_green;
  logic [KW-1:0] s1_blue;

  // most recent depth write, for forwarding
  logic          last_valid;
  logic [AW-1:0] last_addr;
  logic [ZW-1:0] last_depth;

  logic            advance;
  logic            accept;
  logic signed [RW-1:0] xr;
  logic signed [RW-1:0] yr;
  logic            x_ok;
  logic            y_ok;
  logic [AW-1:0]   rd_addr;
  logic [ZW-1:0]   rd_data;
  logic [ZW-1:0]   stored;
  logic            pass;
  logic            upd;
  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [ZW-1:0]   ram_wdata;
  zbp_pkg::pixel_t pix_next;

  assign advance  = !pix_valid || !pix_stall;
  assign pt_stall = clearing || !advance;
  assign accept   = pt_valid && !pt_stall;

  // recentre and clip
  assign xr   = $signed({pt.pos_x[PW-1], pt.pos_x}) + HALF_W;
  assign yr   = $signed({pt.pos_y[PW-1], pt.pos_y}) + HALF_H;
  assign x_ok = !xr[RW-1] && (xr[RW-2:0] < LIMIT_X);
  assign y_ok = !yr[RW-1] && (yr[RW-2:0] < LIMIT_Y);
  assign rd_addr = AW'(xr[RW-2:0]) + AW'(yr[RW-2:0]) * ROW_STEP;

  // depth test on returned data
  assign stored = (last_valid && last_addr == s1_addr) ? last_depth : rd_data;
  assign pass   = s1_ok && !(stored != '0 && s1_depth > stored);
  assign upd    = s1_valid && pass && advance;

  assign ram_we    = clearing || upd;
  assign ram_waddr = clearing ? clr_addr : s1_addr;
  assign ram_wdata = clearing ? '0 : s1_depth;

  always_comb begin
    pix_next = '0;
    if (pass) begin
      pix_next.write_enable = 1'b1;
      pix_next.screen_x     = s1_x;
      pix_next.screen_y     = s1_y;
      pix_next.out_red      = s1_red;
      pix_next.out_green    = s1_green;
      pix_next.out_blue     = s1_blue;
    end
  end

  zbp_ram #(
    .WIDTH(ZW),
    .DEPTH(ENTRIES)
  ) u_zstore (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (accept),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing   <= 1'b1;
      clr_addr   <= '0;
      s1_valid   <= 1'b0;
      pix_valid  <= 1'b0;
      last_valid <= 1'b0;
    end else begin
      if (clearing) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == LAST_ENTRY) begin
          clearing <= 1'b0;
        end
      end
      if (advance) begin
        s1_valid  <= accept;
        pix_valid <= s1_valid;
      end
      if (upd) begin
        last_valid <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ok    <= x_ok && y_ok && !pt.depth[zbp_pkg::DEPTH_W-1];
      s1_addr  <= rd_addr;
      s1_depth <= pt.depth[ZW-1:0];
      s1_x     <= xr[CW-1:0];
      s1_y     <= yr[CW-1:0];
      s1_red   <= pt.red;
      s1_green <= pt.green;
      s1_blue  <= pt.blue;
    end
    if (advance) begin
      pix <= pix_next;
    end
    if (upd) begin
      last_addr  <= s1_addr;
      last_depth <= s1_depth;
    end
  end

  `ZBP_ASSERT(a_no_take_while_clearing, clearing |-> !accept, "point taken during clear sweep")
  `ZBP_ASSERT(a_take_fills_s1, accept |=> s1_valid, "taken point did not reach stage 1")
  `ZBP_ASSERT(a_write_has_item, (ram_we && !clearing) |-> (s1_valid && advance),
    "depth write without a passing point")
  `ZBP_ASSERT(a_no_fwd_in_sweep, clearing |-> !last_valid, "forwarding armed during clear sweep")
  `ZBP_ASSERT(a_drop_is_zero, (pix_valid && !pix.write_enable) |->
    (pix.screen_x == '0 && pix.screen_y == '0 && pix.out_red == '0 &&
     pix.out_green == '0 && pix.out_blue == '0), "dropped pixel carries nonzero fields")

endmodule

// File: hw/rtl/zbp_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies; instanced by zbuffer_pixel_plotter for the depth store.
module zbp_ram #(
  parameter int unsigned WIDTH = 31,
  parameter int unsigned DEPTH = 262144
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
